/* rtl/mts_pkg.sv */
package mts_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_INDEX_BITS = 10;
  localparam int RATE_HZ         = 44100;

  localparam int AMP_W    = 15;
  localparam int LEN_W    = 16;
  localparam int OCT_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;

  localparam logic [OCT_W-1:0] OCT_RESET = OCT_W'(4);
  localparam logic [OCT_W-1:0] OCT_MAX   = OCT_W'(9);
  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(30000);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(13230);

  // quarter-wave sine table, Q30, positions 0 .. QLEN inclusive
  localparam int QLEN   = 1 << (SINE_INDEX_BITS - 2);
  localparam int POS_W  = SINE_INDEX_BITS - 1;
  localparam int QS_W   = 31;
  localparam int PROD_W = AMP_W + QS_W;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NOTE  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_AMPLITUDE   = 1'b0,
    CFG_NOTE_LENGTH = 1'b1
  } cfg_idx_e;

  // one classified item handed from front to back
  typedef struct packed {
    op_e                   op;
    logic [PHASE_BITS-1:0] step;
    logic [OCT_W-1:0]      octave;
  } cmd_t;

  typedef logic [QS_W-1:0]       qsine_t;
  typedef qsine_t                qsine_tab_t [QLEN+1];
  typedef logic [PHASE_BITS-1:0] step_tab_t  [12];

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    longint     x;
    longint     x2;
    longint     p;
    for (int i = 0; i <= QLEN; i++) begin
      x  = longint'(i) <<< (32 - SINE_INDEX_BITS);
      x2 = (x * x) / 64'sd1073741824;
      p  = 64'sd172272;
      p  = -64'sd5026995 + (p * x2) / 64'sd1073741824;
      p  = 64'sd85569306 + (p * x2) / 64'sd1073741824;
      p  = -64'sd693598668 + (p * x2) / 64'sd1073741824;
      p  = 64'sd1686629713 + (p * x2) / 64'sd1073741824;
      p  = (p * x) / 64'sd1073741824;
      if (p < 0) p = 0;
      if (p > 64'sd1073741824) p = 64'sd1073741824;
      tab[i] = QS_W'(p);
    end
    return tab;
  endfunction

  // octave-9 frequencies C9..B9 in Hz, Q8
  function automatic longint top_freq_q8(int semi);
    longint f;
    case (semi)
      0:       f = 2143237;
      1:       f = 2270680;
      2:       f = 2405702;
      3:       f = 2548752;
      4:       f = 2700309;
      5:       f = 2860878;
      6:       f = 3030994;
      7:       f = 3211227;
      8:       f = 3402176;
      9:       f = 3604480;
      10:      f = 3818814;
      default: f = 4045892;
    endcase
    return f;
  endfunction

  function automatic step_tab_t build_steps();
    step_tab_t tab;
    longint    f;
    longint    q;
    longint    r;
    longint    s;
    for (int i = 0; i < 12; i++) begin
      f = top_freq_q8(i);
      q = f / RATE_HZ;
      r = f % RATE_HZ;
      s = ((q <<< PHASE_BITS) + ((r <<< PHASE_BITS) / RATE_HZ)) >>> 8;
      tab[i] = PHASE_BITS'(s);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_TAB = build_qsine();
  localparam step_tab_t  STEP_TAB  = build_steps();

endpackage

/* rtl/mts_in_if.sv */
interface mts_in_if;
  import mts_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] character;

  modport source (output valid, output kind, output character, input ready);
  modport sink   (input valid, input kind, input character, output ready);
endinterface

/* rtl/mts_out_if.sv */
interface mts_out_if;
  import mts_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       note_active;
  logic                       last_of_note;
  logic [OCT_W-1:0]           current_octave;

  modport source (output valid, output sample, output note_active, output last_of_note,
                  output current_octave, input ready);
  modport sink   (input valid, input sample, input note_active, input last_of_note,
                  input current_octave, output ready);
endinterface

/* rtl/mts_front.sv */
module mts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mts_in_if.sink        item_in,
  output mts_pkg::cmd_t cmd_o,
  output logic          push_o,
  input  logic          full_i
);
  import mts_pkg::*;

  logic [OCT_W-1:0] octave_q, octave_d;
  logic [3:0]       semi;
  logic             is_note;
  logic             is_pause;
  logic             accept;

  assign item_in.ready = !full_i;
  assign accept        = item_in.valid && !full_i;
  assign push_o        = accept;

  always_comb begin
    semi     = 4'd0;
    is_note  = 1'b0;
    is_pause = 1'b0;
    octave_d = octave_q;
    cmd_o.op     = OP_NOP;
    cmd_o.step   = '0;
    case (item_in.kind)
      KIND_START: begin
        octave_d = OCT_RESET;
        cmd_o.op = OP_START;
      end
      KIND_TICK: begin
        cmd_o.op = OP_TICK;
      end
      KIND_CHAR: begin
        case (item_in.character)
          8'h3E: if (octave_q < OCT_MAX) octave_d = octave_q + OCT_W'(1);
          8'h3C: if (octave_q != '0) octave_d = octave_q - OCT_W'(1);
          "c": begin is_note = 1'b1; semi = 4'd0;  end
          "d": begin is_note = 1'b1; semi = 4'd2;  end
          "e": begin is_note = 1'b1; semi = 4'd4;  end
          "f": begin is_note = 1'b1; semi = 4'd5;  end
          "g": begin is_note = 1'b1; semi = 4'd7;  end
          "a": begin is_note = 1'b1; semi = 4'd9;  end
          "b": begin is_note = 1'b1; semi = 4'd11; end
          "p": is_pause = 1'b1;
          default: ;
        endcase
        if (is_note || is_pause) cmd_o.op = OP_NOTE;
        // table holds octave 9, lower octaves shift right
        if (is_note) cmd_o.step = STEP_TAB[semi] >> (OCT_MAX - octave_q);
      end
      default: ;
    endcase
    cmd_o.octave = octave_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q <= OCT_RESET;
    end else if (accept) begin
      octave_q <= octave_d;
    end
  end

endmodule

/* rtl/mts_fifo.sv */
module mts_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mts_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mts_pkg::cmd_t rdata_o
);
  import mts_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/mts_back.sv */
module mts_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  mts_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  input  logic [mts_pkg::AMP_W-1:0]  amplitude_i,
  input  logic [mts_pkg::LEN_W-1:0]  note_length_i,
  mts_out_if.source                  item_out
);
  import mts_pkg::*;

  logic [PHASE_BITS-1:0]      phase_q, step_q;
  logic [LEN_W-1:0]           left_q;
  logic                       advance;

  logic [SINE_INDEX_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [POS_W-1:0]           pos;
  logic                       tick_act;

  // stage 1: position within the quarter wave
  logic                       s1_valid_q, s1_act_q, s1_last_q, s1_neg_q;
  logic [POS_W-1:0]           s1_pos_q;
  logic [OCT_W-1:0]           s1_oct_q;
  // stage 2: quarter sine value
  logic                       s2_valid_q, s2_act_q, s2_last_q, s2_neg_q;
  qsine_t                     s2_qs_q;
  logic [OCT_W-1:0]           s2_oct_q;
  // output register
  logic                       out_valid_q;
  logic                       out_act_q, out_last_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [OCT_W-1:0]           out_oct_q;

  logic [PROD_W-1:0]          prod;
  logic [SAMPLE_W-1:0]        mag;

  assign advance = !out_valid_q || item_out.ready;
  assign pop_o   = advance && cmd_valid_i;

  assign idx      = phase_q[PHASE_BITS-1 -: SINE_INDEX_BITS];
  assign quad     = idx[SINE_INDEX_BITS-1 -: 2];
  assign pos      = quad[0] ? (POS_W'(QLEN) - {1'b0, idx[SINE_INDEX_BITS-3:0]})
                            : {1'b0, idx[SINE_INDEX_BITS-3:0]};
  assign tick_act = (cmd_i.op == OP_TICK) && (left_q != '0);

  assign prod = PROD_W'(amplitude_i) * PROD_W'(s2_qs_q);
  assign mag  = SAMPLE_W'(prod >> 30);

  // tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      left_q  <= '0;
    end else if (pop_o) begin
      case (cmd_i.op)
        OP_START: begin
          phase_q <= '0;
          step_q  <= '0;
          left_q  <= '0;
        end
        OP_NOTE: begin
          phase_q <= '0;
          step_q  <= cmd_i.step;
          left_q  <= note_length_i;
        end
        OP_TICK: begin
          if (tick_act) begin
            phase_q <= phase_q + step_q;
            left_q  <= left_q - LEN_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= cmd_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_act_q  <= tick_act;
      s1_last_q <= tick_act && (left_q == LEN_W'(1));
      s1_neg_q  <= quad[1];
      s1_pos_q  <= pos;
      s1_oct_q  <= cmd_i.octave;

      s2_act_q  <= s1_act_q;
      s2_last_q <= s1_last_q;
      s2_neg_q  <= s1_neg_q;
      s2_qs_q   <= s1_act_q ? QSINE_TAB[s1_pos_q] : '0;
      s2_oct_q  <= s1_oct_q;

      out_act_q    <= s2_act_q;
      out_last_q   <= s2_last_q;
      out_sample_q <= s2_neg_q ? -$signed(mag) : $signed(mag);
      out_oct_q    <= s2_oct_q;
    end
  end

  assign item_out.valid          = out_valid_q;
  assign item_out.sample         = out_sample_q;
  assign item_out.note_active    = out_act_q;
  assign item_out.last_of_note   = out_last_q;
  assign item_out.current_octave = out_oct_q;

endmodule

/* rtl/melody_tone_synthesizer.sv */
// Melody tone synthesizer: a DDS tone generator fed by melody characters and
// sample ticks on item_in (kind 0 character, 1 tick, 2 start of melody).
// Every accepted item gives exactly one item on item_out: a tick of a running
// note or pause carries amplitude * sin(phase); other items carry sample 0
// and the octave in effect after the item.
// Configuration: cfg_we_i with cfg_index_i 0 writes amplitude, 1 note_length;
// write only while no item is in flight.
// The queue entry is written at the accept edge; the item then passes the
// quarter-wave position stage, the sine table stage and the multiply into the
// output register.
// Throughput: one item per cycle while item_out is ready; the front classifies
// and computes the note step, the back advances phase and samples one item per
// cycle. When item_out stalls, the back holds and the queue fills; item_in.ready
// drops only once the two queue entries are taken.
// Reset: octave 4, tone silent, amplitude 30000, note_length 13230, queue and
// pipeline empty.
module melody_tone_synthesizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mts_in_if.sink                     item_in,
  mts_out_if.source                  item_out,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [mts_pkg::CFG_W-1:0]  cfg_data_i
);
  import mts_pkg::*;

  logic [AMP_W-1:0] amplitude_q;
  logic [LEN_W-1:0] note_length_q;

  cmd_t push_cmd, head_cmd;
  logic push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q   <= AMP_RESET;
      note_length_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AMPLITUDE:   amplitude_q   <= cfg_data_i[AMP_W-1:0];
        CFG_NOTE_LENGTH: note_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  mts_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_in (item_in),
    .cmd_o   (push_cmd),
    .push_o  (push),
    .full_i  (full)
  );

  mts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_cmd)
  );

  mts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .amplitude_i   (amplitude_q),
    .note_length_i (note_length_q),
    .item_out      (item_out)
  );

endmodule
